### src/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
// No dependencies.
`default_nettype none

package cau_pkg;

  localparam int FRAC_BITS = 16;
  // quotient bits produced by the divide pipeline, one per stage
  localparam int DIV_STEPS = 32;
  // dividend bits kept above the quotient window
  localparam int DIV_SHIFT = DIV_STEPS - FRAC_BITS;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  // one restoring-division lane
  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] nlow;
    logic [31:0] quo;
  } div_lane_t;

  // item carried through the divide stages
  typedef struct packed {
    cmd_t        cmd;
    logic        dz;
    logic        ovf;
    logic [31:0] re;
    logic [31:0] im;
    logic        neg_re;
    logic        neg_im;
    logic        big_re;
    logic        big_im;
    logic [63:0] den;
    div_lane_t   lre;
    div_lane_t   lim;
  } div_item_t;

endpackage

`default_nettype wire

### src/cau_div_stage.sv
// One restoring-division step for both result parts, registered.
// Depends on cau_pkg.
`default_nettype none

module cau_div_stage
  import cau_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  wire logic      in_valid,
  input  wire div_item_t in_item,
  output logic           out_valid,
  output div_item_t      out_item
);

  function automatic div_lane_t lane_step(div_lane_t l, logic [63:0] den);
    logic [64:0] t;
    div_lane_t   o;
    t = {l.rem, l.nlow[31]};
    o.nlow = {l.nlow[30:0], 1'b0};
    if (t >= {1'b0, den}) begin
      o.rem = 64'(t - {1'b0, den});
      o.quo = {l.quo[30:0], 1'b1};
    end else begin
      o.rem = t[63:0];
      o.quo = {l.quo[30:0], 1'b0};
    end
    return o;
  endfunction

  div_item_t item_next;

  always_comb begin
    item_next = in_item;
    item_next.lre = lane_step(in_item.lre, in_item.den);
    item_next.lim = lane_step(in_item.lim, in_item.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

### src/complex_arith_unit.sv
// Complex add/subtract/multiply/divide on signed Q16.16 operands.
// Depends on cau_pkg and cau_div_stage.
//
// Usage:
//   Input stream s_axis carries one operation per transfer: a command and
//   two complex operands. Output stream m_axis returns one result per
//   transfer, in order: real and imaginary parts, saturated to 32 bits,
//   with a divide-by-zero flag and a saturation flag.
//   Each transfer passes through one multiply stage, one sum stage, one
//   normalize stage, 32 divide stages (one quotient bit each) and one
//   saturate stage before its result reaches m_axis. All commands take the
//   same path, so results never reorder.
//   Throughput is one transfer per cycle while the receiver does not stall,
//   set by the fully pipelined multipliers and divider.
//   When the receiver stalls, the result leaving the pipeline drops into a
//   one-entry skid register; s_axis_tready then falls the next cycle and
//   the whole pipeline holds until the skid entry is taken. Nothing is
//   lost or repeated.
//   Reset (rst, synchronous) clears all valid bits; results in flight are
//   dropped.
`default_nettype none

module complex_arith_unit
  import cau_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // command[1:0], a_re[33:2], a_im[65:34], b_re[97:66], b_im[129:98], zero pad
  input  wire logic [135:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // res_re[31:0], res_im[63:32], div_zero[64], overflow[65], zero pad
  output logic [71:0]       m_axis_tdata
);

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  // saturate a 65-bit signed value to 32 bits
  function automatic sat_t sat_wide(logic signed [64:0] v);
    sat_t s;
    if (!v[64] && (|v[63:31])) begin
      s.val = 32'h7FFF_FFFF;
      s.ovf = 1'b1;
    end else if (v[64] && !(&v[63:31])) begin
      s.val = 32'h8000_0000;
      s.ovf = 1'b1;
    end else begin
      s.val = v[31:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

  // saturate a sign/magnitude quotient
  function automatic sat_t sat_quo(logic neg, logic big, logic [31:0] q);
    sat_t s;
    if (big) begin
      s.val = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      s.ovf = 1'b1;
    end else if (!neg) begin
      if (q[31]) begin
        s.val = 32'h7FFF_FFFF;
        s.ovf = 1'b1;
      end else begin
        s.val = q;
        s.ovf = 1'b0;
      end
    end else if (q > 32'h8000_0000) begin
      s.val = 32'h8000_0000;
      s.ovf = 1'b1;
    end else begin
      s.val = 32'(32'd0 - q);
      s.ovf = 1'b0;
    end
    return s;
  endfunction

  logic en;
  logic skid_v;
  logic [65:0] skid;

  assign en            = !skid_v;
  assign s_axis_tready = en;

  // input unpack
  cmd_t               in_cmd;
  logic signed [31:0] ar, ai, br, bi;

  assign in_cmd = cmd_t'(s_axis_tdata[1:0]);
  assign ar     = s_axis_tdata[33:2];
  assign ai     = s_axis_tdata[65:34];
  assign br     = s_axis_tdata[97:66];
  assign bi     = s_axis_tdata[129:98];

  // stage 1: products and add/sub
  logic               v1;
  cmd_t               cmd1;
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir, p_br2, p_bi2;
  logic signed [32:0] as_re, as_im;
  logic signed [32:0] as_re_next, as_im_next;

  always_comb begin
    if (in_cmd == CMD_SUB) begin
      as_re_next = {ar[31], ar} - {br[31], br};
      as_im_next = {ai[31], ai} - {bi[31], bi};
    end else begin
      as_re_next = {ar[31], ar} + {br[31], br};
      as_im_next = {ai[31], ai} + {bi[31], bi};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1  <= in_cmd;
      p_rr  <= ar * br;
      p_ii  <= ai * bi;
      p_ri  <= ar * bi;
      p_ir  <= ai * br;
      p_br2 <= br * br;
      p_bi2 <= bi * bi;
      as_re <= as_re_next;
      as_im <= as_im_next;
    end
  end

  // stage 2: sums of products, divisor
  logic               v2;
  cmd_t               cmd2;
  logic signed [64:0] sr2, si2;
  logic [63:0]        den2;
  logic signed [64:0] sr_next, si_next;
  logic [63:0]        den_next;

  always_comb begin
    den_next = p_br2 + p_bi2;
    case (cmd1)
      CMD_MUL: begin
        sr_next = {p_rr[63], p_rr} - {p_ii[63], p_ii};
        si_next = {p_ri[63], p_ri} + {p_ir[63], p_ir};
      end
      CMD_DIV: begin
        sr_next = {p_rr[63], p_rr} + {p_ii[63], p_ii};
        si_next = {p_ir[63], p_ir} - {p_ri[63], p_ri};
      end
      default: begin
        sr_next = {{32{as_re[32]}}, as_re};
        si_next = {{32{as_im[32]}}, as_im};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd2 <= cmd1;
      sr2  <= sr_next;
      si2  <= si_next;
      den2 <= den_next;
    end
  end

  // stage 3: saturate add/sub/mul, set up division lanes
  logic               v3;
  div_item_t          it3;
  div_item_t          it3_next;
  logic signed [64:0] vre, vim;
  logic [63:0]        mre, mim;
  sat_t               s_re, s_im;

  always_comb begin
    vre = (cmd2 == CMD_MUL) ? (sr2 >>> FRAC_BITS) : sr2;
    vim = (cmd2 == CMD_MUL) ? (si2 >>> FRAC_BITS) : si2;
    s_re = sat_wide(vre);
    s_im = sat_wide(vim);
    mre = sr2[64] ? 64'(-sr2) : sr2[63:0];
    mim = si2[64] ? 64'(-si2) : si2[63:0];

    it3_next.cmd      = cmd2;
    it3_next.dz       = (cmd2 == CMD_DIV) && (den2 == 64'd0);
    it3_next.ovf      = s_re.ovf | s_im.ovf;
    it3_next.re       = s_re.val;
    it3_next.im       = s_im.val;
    it3_next.neg_re   = sr2[64];
    it3_next.neg_im   = si2[64];
    it3_next.big_re   = (mre >> DIV_SHIFT) >= den2;
    it3_next.big_im   = (mim >> DIV_SHIFT) >= den2;
    it3_next.den      = den2;
    it3_next.lre.rem  = mre >> DIV_SHIFT;
    it3_next.lre.nlow = 32'(mre << FRAC_BITS);
    it3_next.lre.quo  = '0;
    it3_next.lim.rem  = mim >> DIV_SHIFT;
    it3_next.lim.nlow = 32'(mim << FRAC_BITS);
    it3_next.lim.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it3 <= it3_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // divide stages
  logic      dv [0:DIV_STEPS];
  div_item_t di [0:DIV_STEPS];

  assign dv[0] = v3;
  assign di[0] = it3;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    cau_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (dv[k]),
      .in_item  (di[k]),
      .out_valid(dv[k+1]),
      .out_item (di[k+1])
    );
  end

  // final stage: quotient saturation and result select
  div_item_t   dl;
  sat_t        q_re, q_im;
  logic [65:0] res_next;
  logic [65:0] res;
  logic        pv;

  assign dl = di[DIV_STEPS];

  always_comb begin
    q_re = sat_quo(dl.neg_re, dl.big_re, dl.lre.quo);
    q_im = sat_quo(dl.neg_im, dl.big_im, dl.lim.quo);
    if (dl.cmd == CMD_DIV) begin
      if (dl.dz) begin
        res_next = {1'b0, 1'b1, 32'd0, 32'd0};
      end else begin
        res_next = {q_re.ovf | q_im.ovf, 1'b0, q_im.val, q_re.val};
      end
    end else begin
      res_next = {dl.ovf, 1'b0, dl.im, dl.re};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= dv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

  // skid entry catches the result that leaves while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (m_axis_tready) begin
        skid_v <= 1'b0;
      end
    end else if (pv && !m_axis_tready) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v && pv && !m_axis_tready) begin
      skid <= res;
    end
  end

  assign m_axis_tvalid = pv || skid_v;
  assign m_axis_tdata  = {6'd0, skid_v ? skid : res};

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for complex_arith_unit: add, subtract, multiply and divide
// on signed Q16.16 operands, checked against an in-bench fixed-point predictor.
// Depends on cau_pkg and the complex_arith_unit RTL.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        dz;
    logic        ovf;
  } cplx_res_t;

  // saturate a signed 128-bit value to 32 bits
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // quotient truncated toward zero
  function automatic logic signed [127:0] quot_tz(input logic signed [127:0] n,
                                                  input logic signed [127:0] d);
    logic signed [127:0] m;
    logic signed [127:0] q;
    m = (n < 0) ? -n : n;
    q = m / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic cplx_res_t cplx_predict(input cmd_t op,
      input logic signed [31:0] ar, ai, br, bi);
    cplx_res_t r;
    logic signed [127:0] xr, xi, den;
    logic ovf;
    ovf = 1'b0;
    r = '0;
    case (op)
      CMD_ADD: begin
        xr = 128'(ar) + 128'(br);
        xi = 128'(ai) + 128'(bi);
      end
      CMD_SUB: begin
        xr = 128'(ar) - 128'(br);
        xi = 128'(ai) - 128'(bi);
      end
      CMD_MUL: begin
        // arithmetic shift floors
        xr = (128'(ar) * 128'(br) - 128'(ai) * 128'(bi)) >>> FRAC_BITS;
        xi = (128'(ar) * 128'(bi) + 128'(ai) * 128'(br)) >>> FRAC_BITS;
      end
      default: begin
        den = 128'(br) * 128'(br) + 128'(bi) * 128'(bi);
        xr = 0;
        xi = 0;
        if (den == 0) r.dz = 1'b1;
        else begin
          xr = quot_tz((128'(ar) * 128'(br) + 128'(ai) * 128'(bi)) <<< FRAC_BITS, den);
          xi = quot_tz((128'(ai) * 128'(br) - 128'(ar) * 128'(bi)) <<< FRAC_BITS, den);
        end
      end
    endcase
    r.re = clamp32(xr, ovf);
    r.im = clamp32(xi, ovf);
    r.ovf = ovf;
    return r;
  endfunction

  class cplx_scoreboard;
    cplx_res_t pending[$];
    int errors = 0;

    function void note_input(logic [135:0] d);
      pending.push_back(cplx_predict(cmd_t'(d[1:0]), d[33:2], d[65:34], d[97:66],
                                     d[129:98]));
    endfunction

    function void check_result(logic [71:0] d);
      cplx_res_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.re) begin
        $error("res_re expected %h got %h", e.re, d[31:0]);
        errors++;
      end
      if (d[63:32] !== e.im) begin
        $error("res_im expected %h got %h", e.im, d[63:32]);
        errors++;
      end
      if (d[64] !== e.dz) begin
        $error("div_zero expected %b got %b", e.dz, d[64]);
        errors++;
      end
      if (d[65] !== e.ovf) begin
        $error("overflow expected %b got %b", e.ovf, d[65]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  int src_idle_pct = 22;
  int snk_idle_pct = 59;
  int hold_cycles = 0;

  cplx_scoreboard sb = new();

  complex_arith_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic send_op(input cmd_t op, input logic [31:0] ar, ai, br, bi);
    logic [135:0] d;
    d = {6'd0, bi, br, ai, ar, op};
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(d);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(7))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return $urandom_range(2);
      3: return 32'($signed($urandom_range(16'hFFFF)) - 32'sh8000) <<< 8;
      4: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    logic [31:0] ext[5];
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000, 32'hFFFF_FFFF};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes for each command, zero divisor, tiny divisor
    for (int c = 0; c < 4; c++) begin
      send_op(cmd_t'(c), ext[0], ext[1], ext[0], ext[0]);
      send_op(cmd_t'(c), ext[1], ext[0], ext[1], ext[1]);
      send_op(cmd_t'(c), ext[3], ext[4], ext[4], ext[3]);
      send_op(cmd_t'(c), ext[1], ext[1], ext[2], ext[4]);
    end
    send_op(CMD_DIV, ext[1], ext[0], 32'h0, 32'h0);
    send_op(CMD_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
    send_op(CMD_DIV, 32'h0003_0000, 32'h0, 32'h0002_0000, 32'h0);
    send_op(CMD_DIV, 32'hFFFD_0000, 32'h0, 32'h0002_0000, 32'h0);
    drain();

    // long receiver hold-off while the sender keeps pushing
    hold_cycles = 200;
    src_idle_pct = 0;
    for (int i = 0; i < 150; i++)
      send_op(cmd_t'($urandom_range(3)), rnd_val(), rnd_val(), rnd_val(), rnd_val());
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 59 : 0;
      snk_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 22 : 0;
      for (int i = 0; i < 620; i++) begin
        if ($urandom_range(15) == 0)
          send_op(CMD_DIV, rnd_val(), rnd_val(), 32'h0, 32'h0);
        else
          send_op(cmd_t'($urandom_range(3)), rnd_val(), rnd_val(), rnd_val(), rnd_val());
      end
    end
    drain();

    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

`default_nettype wire
